// ===== hw/rtl/stst_pkg.sv =====
// ----------------------------------------------------------------------------
// stst_pkg
// Shared types and constants of the software timeout slot table.
// ----------------------------------------------------------------------------
package stst_pkg;

	// default number of timeout slots
	localparam int SLOTS_DEFAULT = 10;

	// loop delay after reset, in ms
	localparam logic [9:0] LOOP_MS_RESET = 10'd10;

	// operation codes of an input transaction
	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_TIMEOUT = 2'd1,
		OP_ACTIVE  = 2'd2,
		OP_CANCEL  = 2'd3
	} op_t;

	// result codes
	typedef enum logic [1:0] {
		RES_NO      = 2'd0,
		RES_YES     = 2'd1,
		RES_FULL    = 2'd2,
		RES_MISSING = 2'd3
	} res_t;

	// slot modes
	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_ARMED = 2'd1,
		MODE_HELD  = 2'd2
	} slot_mode_t;

	// one timeout slot
	typedef struct packed {
		slot_mode_t  mode;
		logic        fired;
		logic [15:0] duration;
		logic [15:0] deadline;
	} slot_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_DONE
	} seq_state_t;

endpackage

// ===== hw/rtl/stst_slot_file.sv =====
// ----------------------------------------------------------------------------
// stst_slot_file
// Register file of timeout slots: one read port, one write port, reset idle.
// ----------------------------------------------------------------------------
module stst_slot_file import stst_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT,
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] rd_idx,
	output slot_t         rd_slot,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_idx,
	input  slot_t         wr_slot
);

	slot_t slots_q [SLOTS];

	// slot storage, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slots_q[i] <= '0;
			end
		end else if (wr_en) begin
			slots_q[wr_idx] <= wr_slot;
		end
	end

	// read port
	assign rd_slot = slots_q[rd_idx];

endmodule

// ===== hw/rtl/software_timeout_slot_table.sv =====
// ----------------------------------------------------------------------------
// software_timeout_slot_table
// Timeout slots keyed by duration, driven by tick and query transactions.
// ----------------------------------------------------------------------------
// Usage:
//   An input transaction (operation, duration_ms, machine_state) is taken
//   when in_valid is high and in_stall is low. Every input transaction
//   gives exactly one output transaction carrying result_code, offered on
//   out_valid and taken when out_stall is low.
//   After acceptance a single compare path walks the slot file, one slot
//   per cycle; then the chosen slot is updated, and then the output
//   register loads, waiting while it holds an untaken result. The next
//   transaction is accepted only once that load has happened, so a new
//   transaction is never taken while the last one is in progress.
//   A result waiting under out_stall does not block the next transaction;
//   only the following result holds until the register is free.
//   The loop period must be written through cfg_we / cfg_wdata only while idle; the block itself does not enforce this.
//   Reset clears all slots, the tick count and the last machine state,
//   and sets the loop delay to 10 ms.
// ----------------------------------------------------------------------------
module software_timeout_slot_table import stst_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [15:0] duration_ms,
	input  logic [7:0]  machine_state,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_code,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	seq_state_t  state_q, state_d;
	op_t         op_q;
	logic [15:0] dur_q;
	logic [7:0]  ms_q;
	logic [9:0]  delay_q;
	logic [15:0] tick_q;
	logic [7:0]  last_ms_q;
	logic [IW-1:0] idx_q;
	logic        key_found_q, idle_found_q;
	logic [IW-1:0] key_idx_q, idle_idx_q;
	res_t        code_q, code_d, code_hold_q;
	logic        out_valid_q;

	logic [IW-1:0] rd_idx;
	slot_t       rd_slot;
	logic        wr_en;
	logic [IW-1:0] wr_idx;
	slot_t       wr_slot;

	logic        accept, out_take, out_load;
	logic        key_hit, idle_hit, state_changed;
	logic [15:0] offset, deadline;

	stst_slot_file #(.SLOTS(SLOTS)) u_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (rd_idx),
		.rd_slot (rd_slot),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_slot (wr_slot)
	);

	// handshakes
	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid && !in_stall;
	assign out_take    = out_valid_q && !out_stall;
	assign out_load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid   = out_valid_q;
	assign result_code = code_q;

	// shared compare path on the slot being examined
	assign rd_idx        = (state_q == ST_ACT) ? key_idx_q : idx_q;
	assign key_hit       = (rd_slot.duration == dur_q);
	assign idle_hit      = (rd_slot.mode == MODE_IDLE);
	assign state_changed = (ms_q != last_ms_q);

	// deadline of a newly armed slot
	assign offset   = (op_q == OP_TIMEOUT) ? {5'd0, delay_q, 1'b0} : {6'd0, delay_q};
	assign deadline = tick_q + dur_q - offset;

	// sequencer next state, slot writes and result code
	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		wr_idx  = idx_q;
		wr_slot = rd_slot;
		code_d  = code_hold_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (op_q == OP_TICK) begin
					if (state_changed) begin
						wr_en   = 1'b1;
						wr_slot = '0;
					end else if (rd_slot.mode == MODE_ARMED && rd_slot.deadline == tick_q) begin
						wr_en         = 1'b1;
						wr_slot.fired = 1'b1;
					end
				end
				if (idx_q == LAST_IDX) begin
					state_d = ST_ACT;
				end
			end
			ST_ACT: begin
				state_d = ST_DONE;
				wr_idx  = key_idx_q;
				code_d  = RES_NO;
				unique case (op_q)
					OP_TICK: begin
						code_d = RES_NO;
					end
					OP_TIMEOUT: begin
						if (dur_q <= {6'd0, delay_q}) begin
							code_d = RES_YES;
						end else if (!key_found_q) begin
							if (idle_found_q) begin
								wr_en   = 1'b1;
								wr_idx  = idle_idx_q;
								wr_slot = '{mode: MODE_ARMED, fired: 1'b0,
								            duration: dur_q, deadline: deadline};
								code_d  = RES_NO;
							end else begin
								code_d = RES_FULL;
							end
						end else if (rd_slot.mode != MODE_IDLE && rd_slot.fired) begin
							wr_en            = 1'b1;
							wr_slot.mode     = MODE_IDLE;
							wr_slot.fired    = 1'b0;
							wr_slot.duration = '0;
							code_d           = RES_YES;
						end else begin
							code_d = RES_NO;
						end
					end
					OP_ACTIVE: begin
						if (!key_found_q) begin
							if (idle_found_q) begin
								wr_en   = 1'b1;
								wr_idx  = idle_idx_q;
								wr_slot = '{mode: MODE_ARMED, fired: 1'b0,
								            duration: dur_q, deadline: deadline};
								code_d  = RES_YES;
							end else begin
								code_d = RES_FULL;
							end
						end else if (rd_slot.mode == MODE_HELD) begin
							code_d = RES_NO;
						end else if (rd_slot.mode != MODE_IDLE && rd_slot.fired) begin
							wr_en         = 1'b1;
							wr_slot.mode  = MODE_HELD;
							wr_slot.fired = 1'b0;
							code_d        = RES_NO;
						end else begin
							code_d = RES_YES;
						end
					end
					OP_CANCEL: begin
						if (key_found_q) begin
							wr_en   = 1'b1;
							wr_slot = '0;
							code_d  = RES_NO;
						end else begin
							code_d = RES_MISSING;
						end
					end
					default: begin
						code_d = RES_NO;
					end
				endcase
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= LOOP_MS_RESET;
		end else if (cfg_we) begin
			delay_q <= cfg_wdata;
		end
	end

	// tick count and last machine state, updated when a tick finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			last_ms_q <= '0;
		end else if (state_q == ST_ACT && op_q == OP_TICK) begin
			tick_q    <= tick_q + 16'd1;
			last_ms_q <= ms_q;
		end
	end

	// captured transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(operation);
			dur_q <= duration_ms;
			ms_q  <= machine_state;
		end
	end

	// slot walk: index and lowest key and idle matches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			key_found_q  <= 1'b0;
			idle_found_q <= 1'b0;
			key_idx_q    <= '0;
			idle_idx_q   <= '0;
		end else if (accept) begin
			idx_q        <= '0;
			key_found_q  <= 1'b0;
			idle_found_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			if (idx_q != LAST_IDX) begin
				idx_q <= idx_q + IW'(1);
			end
			if (key_hit && !key_found_q) begin
				key_found_q <= 1'b1;
				key_idx_q   <= idx_q;
			end
			if (idle_hit && !idle_found_q) begin
				idle_found_q <= 1'b1;
				idle_idx_q   <= idx_q;
			end
		end
	end

	// result code held from the update cycle until the output register loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_hold_q <= RES_NO;
		end else if (state_q == ST_ACT) begin
			code_hold_q <= code_d;
		end
	end

	// output register payload, changes only when a new result loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= RES_NO;
		end else if (out_load) begin
			code_q <= code_hold_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timeout slot table. Directed transactions walk
// the edge cases of arming, firing, holding, cancelling, table full and the
// idle key match; random traffic then runs under several loop delays, mostly
// with random gaps on the input side and random stalls on the output side, and
// last back to back without them. Every result is checked against an in-bench
// model of the slot table.
module tb_top import stst_pkg::*; ();

	localparam int SLOTS = SLOTS_DEFAULT;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [15:0] duration_ms;
	logic [7:0]  machine_state;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  result_code;
	logic        cfg_we;
	logic [9:0]  cfg_wdata;

	// model of the slot table
	slot_t       slot_tab [SLOTS];
	logic [15:0] tick_now;
	logic [7:0]  last_state;
	logic [9:0]  loop_ms;

	// codes still owed by the block, oldest first
	res_t        pending_codes [$];
	int          error_count;
	bit          idle_on;
	logic [7:0]  app_state;

	software_timeout_slot_table #(.SLOTS(SLOTS)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.duration_ms  (duration_ms),
		.machine_state(machine_state),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_code  (result_code),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic report(input string what);
		$display("ERROR at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// lowest slot holding the key, -1 if none
	function automatic int find_key(input logic [15:0] d);
		for (int i = 0; i < SLOTS; i++)
			if (slot_tab[i].duration == d)
				return i;
		return -1;
	endfunction

	// arm the lowest idle slot, 0 when the table is full
	function automatic bit arm_slot(input logic [15:0] d, input logic [15:0] offset);
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_tab[i].mode == MODE_IDLE) begin
				slot_tab[i].mode     = MODE_ARMED;
				slot_tab[i].fired    = 1'b0;
				slot_tab[i].duration = d;
				slot_tab[i].deadline = tick_now + d - offset;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// advance the model by one transaction and give its result code
	function automatic res_t timeout_table_step(input op_t op, input logic [15:0] d,
			input logic [7:0] ms);
		int   k;
		res_t code;
		code = RES_NO;
		case (op)
			OP_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (ms != last_state)
						slot_tab[i] = '0;
					else if (slot_tab[i].mode == MODE_ARMED && slot_tab[i].deadline == tick_now)
						slot_tab[i].fired = 1'b1;
				end
				last_state = ms;
				tick_now   = tick_now + 16'd1;
			end
			OP_TIMEOUT: begin
				if (d <= {6'd0, loop_ms}) begin
					code = RES_YES;
				end else begin
					k = find_key(d);
					if (k < 0) begin
						code = arm_slot(d, {5'd0, loop_ms, 1'b0}) ? RES_NO : RES_FULL;
					end else if (slot_tab[k].mode != MODE_IDLE && slot_tab[k].fired) begin
						// fired slot is freed, deadline stays
						slot_tab[k].mode     = MODE_IDLE;
						slot_tab[k].fired    = 1'b0;
						slot_tab[k].duration = 16'd0;
						code = RES_YES;
					end
				end
			end
			OP_ACTIVE: begin
				k = find_key(d);
				if (k < 0) begin
					code = arm_slot(d, {6'd0, loop_ms}) ? RES_YES : RES_FULL;
				end else if (slot_tab[k].mode == MODE_HELD) begin
					code = RES_NO;
				end else if (slot_tab[k].mode != MODE_IDLE && slot_tab[k].fired) begin
					slot_tab[k].mode  = MODE_HELD;
					slot_tab[k].fired = 1'b0;
					code = RES_NO;
				end else begin
					code = RES_YES;
				end
			end
			default: begin
				k = find_key(d);
				if (k < 0)
					code = RES_MISSING;
				else
					slot_tab[k] = '0;
			end
		endcase
		return code;
	endfunction

	// send one transaction, optionally after a gap, and log its expected code
	task automatic send_item(input op_t op, input logic [15:0] d, input logic [7:0] ms);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 2) == 0)
			gap = $urandom_range(1, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		duration_ms   <= d;
		machine_state <= ms;
		do
			@(posedge clk);
		while (in_stall);
		pending_codes.push_back(timeout_table_step(op, d, ms));
	endtask

	// stop sending and wait until every owed result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_codes.size() != 0);
	endtask

	task automatic write_loop_ms(input logic [9:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		loop_ms = value;
		cfg_we    <= 1'b0;
	endtask

	// random traffic: mostly ticks and queries on a few reusable keys
	task automatic run_random(input int count);
		int          pick;
		logic [15:0] d;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 48) begin
				if ($urandom_range(0, 39) == 0)
					app_state = 8'($urandom_range(0, 255));
				send_item(OP_TICK, 16'($urandom_range(0, 65535)), app_state);
			end else if (pick < 68) begin
				d = {5'd0, loop_ms, 1'b0} + 16'($urandom_range(1, 8) * 3);
				send_item(OP_TIMEOUT, d, 8'($urandom_range(0, 255)));
			end else if (pick < 84) begin
				d = {6'd0, loop_ms} + 16'($urandom_range(1, 8) * 3);
				send_item(OP_ACTIVE, d, 8'($urandom_range(0, 255)));
			end else if (pick < 93) begin
				d = {6'd0, loop_ms} << $urandom_range(0, 1);
				d = d + 16'($urandom_range(1, 8) * 3);
				send_item(OP_CANCEL, d, 8'($urandom_range(0, 255)));
			end else begin
				// noise: any field value at all
				send_item(op_t'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)));
			end
		end
	endtask

	// edge cases at the reset loop delay
	task automatic test_directed();
		send_item(OP_TICK, 16'h0000, 8'h00);
		send_item(OP_TIMEOUT, 16'd0, 8'h00);
		send_item(OP_TIMEOUT, 16'd10, 8'h00);
		// deadline wraps below zero
		send_item(OP_TIMEOUT, 16'd11, 8'h00);
		// idle slot matches key zero
		send_item(OP_ACTIVE, 16'd0, 8'h00);
		send_item(OP_CANCEL, 16'd0, 8'h00);
		send_item(OP_CANCEL, 16'd12345, 8'h00);
		send_item(OP_TIMEOUT, 16'd25, 8'h00);
		send_item(OP_ACTIVE, 16'd15, 8'h00);
		repeat (6) send_item(OP_TICK, 16'hFFFF, 8'h00);
		send_item(OP_TIMEOUT, 16'd25, 8'h00);
		send_item(OP_TIMEOUT, 16'd25, 8'h00);
		send_item(OP_ACTIVE, 16'd15, 8'h00);
		send_item(OP_ACTIVE, 16'd15, 8'h00);
		send_item(OP_CANCEL, 16'd15, 8'h00);
		send_item(OP_TIMEOUT, 16'hFFFF, 8'hFF);
		send_item(OP_ACTIVE, 16'hFFFF, 8'hFF);
		// state change clears the table
		send_item(OP_TICK, 16'h0000, 8'hFF);
		send_item(OP_TICK, 16'h0000, 8'hFF);
		send_item(OP_CANCEL, 16'hFFFF, 8'h00);
		drain_results();
	endtask

	// fill all slots, then arming requests must report a full table until a cancel frees a slot
	task automatic test_table_full();
		for (int i = 0; i < SLOTS; i++)
			send_item(OP_ACTIVE, 16'(100 + i), 8'hFF);
		send_item(OP_ACTIVE, 16'd500, 8'hFF);
		send_item(OP_TIMEOUT, 16'd600, 8'hFF);
		send_item(OP_ACTIVE, 16'd0, 8'hFF);
		send_item(OP_CANCEL, 16'd103, 8'hFF);
		send_item(OP_ACTIVE, 16'd0, 8'hFF);
		send_item(OP_CANCEL, 16'd0, 8'hFF);
		send_item(OP_TICK, 16'd0, 8'h5A);
		app_state = 8'h5A;
		drain_results();
	endtask

	// loop delay at and near the ends of its 10-bit range
	task automatic test_loop_ms_extremes();
		logic [9:0] settings [4];
		settings = '{10'd1000, 10'd1, 10'd0, 10'd1023};
		foreach (settings[i]) begin
			write_loop_ms(settings[i]);
			send_item(OP_TIMEOUT, {6'd0, settings[i]}, app_state);
			send_item(OP_TIMEOUT, {6'd0, settings[i]} + 16'd1, app_state);
			run_random(40);
			drain_results();
		end
	endtask

	// a few random loop delays, back to the reset value at the end
	task automatic test_random_settings();
		for (int i = 0; i < 3; i++) begin
			write_loop_ms(10'($urandom_range(1, 1000)));
			run_random(80);
			drain_results();
		end
		write_loop_ms(LOOP_MS_RESET);
		run_random(20);
	endtask

	// back-to-back traffic with no gaps and no stalls
	task automatic test_streaming();
		idle_on = 1'b0;
		run_random(60);
	endtask

	// output side stalls in random bursts
	initial begin : stall_gen
		int n;
		out_stall = 1'b0;
		forever begin
			n = $urandom_range(1, 16);
			repeat (n) @(posedge clk);
			out_stall <= idle_on && ($urandom_range(0, 2) == 0);
		end
	end

	// compare each taken result with the oldest owed code
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_codes.size() == 0)
				report($sformatf("unexpected result_code %0d", result_code));
			else if (result_code !== pending_codes[0])
				report($sformatf("result_code %0d, want %0d", result_code, pending_codes[0]));
			if (pending_codes.size() != 0)
				void'(pending_codes.pop_front());
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("software_timeout_slot_table: mismatch");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		operation     = OP_TICK;
		duration_ms   = 16'd0;
		machine_state = 8'd0;
		cfg_we        = 1'b0;
		cfg_wdata     = 10'd0;
		error_count   = 0;
		idle_on       = 1'b1;
		app_state     = 8'd0;
		tick_now      = 16'd0;
		last_state    = 8'd0;
		loop_ms       = LOOP_MS_RESET;
		foreach (slot_tab[i])
			slot_tab[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_table_full();
		test_loop_ms_extremes();
		test_random_settings();
		test_streaming();

		drain_results();
		repeat (2 * (SLOTS + 3)) @(posedge clk);
		if (error_count == 0)
			$display("software_timeout_slot_table: match");
		else
			$display("software_timeout_slot_table: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/stst_pkg.sv
hw/rtl/stst_slot_file.sv
hw/rtl/software_timeout_slot_table.sv
test/tb_top.sv
